// File: rtl/core/csau_pkg.sv
// ---------------------------------------------------------------------------
// csau_pkg
// shared types, codes and helpers for the swept bounding box update core
// ---------------------------------------------------------------------------
package csau_pkg;

   localparam int unsigned CMD_QUEUE_DEPTH = 2;

   localparam logic [1:0] SHAPE_NONE   = 2'd0;
   localparam logic [1:0] SHAPE_SPHERE = 2'd1;
   localparam logic [1:0] SHAPE_BOX    = 2'd2;

   localparam logic [2:0] REG_SHAPE_KIND    = 3'd0;
   localparam logic [2:0] REG_OFFSET_X      = 3'd1;
   localparam logic [2:0] REG_OFFSET_Y      = 3'd2;
   localparam logic [2:0] REG_OFFSET_Z      = 3'd3;
   localparam logic [2:0] REG_BOX_WIDTH     = 3'd4;
   localparam logic [2:0] REG_BOX_HEIGHT    = 3'd5;
   localparam logic [2:0] REG_BOX_LENGTH    = 3'd6;
   localparam logic [2:0] REG_SPHERE_RADIUS = 3'd7;

   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   // classified transaction handed from front to back
   typedef struct packed {
      logic [1:0]         shape;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic signed [15:0] qw;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
   } cmd_type;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sh07fffffff) r = SAT_MAX;
      else if (v < -33'sh080000000) r = SAT_MIN;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat38(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > 38'sh7fffffff) r = SAT_MAX;
      else if (v < -38'sh80000000) r = SAT_MIN;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// File: rtl/core/csau_front.sv
// ---------------------------------------------------------------------------
// csau_front
// accepts transactions, forms the center and queues the classified command
// ---------------------------------------------------------------------------
module csau_front #(
   parameter int unsigned QUEUE_DEPTH = csau_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_pos_x,
   input  logic signed [31:0]      req_pos_y,
   input  logic signed [31:0]      req_pos_z,
   input  logic signed [15:0]      req_quat_w,
   input  logic signed [15:0]      req_quat_x,
   input  logic signed [15:0]      req_quat_y,
   input  logic signed [15:0]      req_quat_z,
   input  logic [1:0]              shape_kind,
   input  logic signed [31:0]      offset_x,
   input  logic signed [31:0]      offset_y,
   input  logic signed [31:0]      offset_z,
   output logic                    cmd_valid,
   output csau_pkg::cmd_type       cmd_data,
   input  logic                    cmd_take
);

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   csau_pkg::cmd_type       q_ff [QUEUE_DEPTH];
   logic [PW-1:0]           wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   csau_pkg::cmd_type       c;
   logic                    push;

   assign req_stall = (cnt_ff == CW'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rp_ff];

   always_comb begin
      c.shape = (shape_kind == csau_pkg::SHAPE_SPHERE || shape_kind == csau_pkg::SHAPE_BOX)
                ? shape_kind : csau_pkg::SHAPE_NONE;
      c.cx = csau_pkg::sat33(33'(req_pos_x) + 33'(offset_x));
      c.cy = csau_pkg::sat33(33'(req_pos_y) + 33'(offset_y));
      c.cz = csau_pkg::sat33(33'(req_pos_z) + 33'(offset_z));
      c.qw = req_quat_w;
      c.qx = req_quat_x;
      c.qy = req_quat_y;
      c.qz = req_quat_z;
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (cmd_take) begin
         rp_in = (rp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !cmd_take) cnt_in = cnt_ff + 1'b1;
      else if (!push && cmd_take) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= c;
   end

endmodule

// File: rtl/core/csau_back.sv
// ---------------------------------------------------------------------------
// csau_back
// sequenced box evaluation on one shared multiplier, union and output stage
// ---------------------------------------------------------------------------
module csau_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  csau_pkg::cmd_type       cmd_data,
   output logic                    cmd_take,
   input  logic [30:0]             box_width,
   input  logic [30:0]             box_height,
   input  logic [30:0]             box_length,
   input  logic [30:0]             sphere_radius,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_swept_lo_x,
   output logic signed [31:0]      rsp_swept_lo_y,
   output logic signed [31:0]      rsp_swept_lo_z,
   output logic signed [31:0]      rsp_swept_hi_x,
   output logic signed [31:0]      rsp_swept_hi_y,
   output logic signed [31:0]      rsp_swept_hi_z,
   output logic signed [31:0]      rsp_move_dx,
   output logic signed [31:0]      rsp_move_dy,
   output logic signed [31:0]      rsp_move_dz
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_QUAT = 3'd1;
   localparam logic [2:0] ST_MAT  = 3'd2;
   localparam logic [2:0] ST_EXT  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]               st_ff, st_in;
   logic [3:0]               k_ff, k_in;
   logic [1:0]               col_ff, col_in;
   logic [1:0]               row_ff, row_in;
   csau_pkg::cmd_type        cur_ff;
   logic signed [31:0]       prod [9];    // quaternion products, Q.28
   logic signed [32:0]       pr_ff [9];
   logic [17:0]              mag_ff [9];
   logic [50:0]              acc_ff [3];
   logic signed [31:0]       lc_ff [3];
   logic signed [31:0]       lb_ff [6];
   logic                     primed_ff;
   logic signed [31:0]       ob_ff [9];
   logic                     ov_ff;
   logic signed [35:0]       m [9];
   logic [17:0]              mul_a;
   logic [30:0]              mul_b;
   logic [48:0]              mul_p;
   logic signed [31:0]       nb [6];
   logic signed [31:0]       c [3];
   logic [35:0]              e;
   logic                     out_free;

   assign out_free = !ov_ff || !rsp_stall;
   assign cmd_take = (st_ff == ST_IDLE) && cmd_valid;
   assign c[0] = cur_ff.cx;
   assign c[1] = cur_ff.cy;
   assign c[2] = cur_ff.cz;

   // xx yy zz xy xz yz wx wy wz (one product per entry)
   always_comb begin
      prod[0] = cur_ff.qx * cur_ff.qx;
      prod[1] = cur_ff.qy * cur_ff.qy;
      prod[2] = cur_ff.qz * cur_ff.qz;
      prod[3] = cur_ff.qx * cur_ff.qy;
      prod[4] = cur_ff.qx * cur_ff.qz;
      prod[5] = cur_ff.qy * cur_ff.qz;
      prod[6] = cur_ff.qw * cur_ff.qx;
      prod[7] = cur_ff.qw * cur_ff.qy;
      prod[8] = cur_ff.qw * cur_ff.qz;
   end

   always_comb begin
      m[0] = 36'sd268435456 - 36'(2 * (36'(pr_ff[1]) + 36'(pr_ff[2])));
      m[1] = 36'(2 * (36'(pr_ff[3]) - 36'(pr_ff[8])));
      m[2] = 36'(2 * (36'(pr_ff[4]) + 36'(pr_ff[7])));
      m[3] = 36'(2 * (36'(pr_ff[3]) + 36'(pr_ff[8])));
      m[4] = 36'sd268435456 - 36'(2 * (36'(pr_ff[0]) + 36'(pr_ff[2])));
      m[5] = 36'(2 * (36'(pr_ff[5]) - 36'(pr_ff[6])));
      m[6] = 36'(2 * (36'(pr_ff[4]) - 36'(pr_ff[7])));
      m[7] = 36'(2 * (36'(pr_ff[5]) + 36'(pr_ff[6])));
      m[8] = 36'sd268435456 - 36'(2 * (36'(pr_ff[0]) + 36'(pr_ff[1])));
   end

   // shared multiplier: one matrix magnitude times one dimension per cycle
   always_comb begin
      mul_a = mag_ff[k_ff];
      case (col_ff)
         2'd0:    mul_b = box_width;
         2'd1:    mul_b = box_height;
         default: mul_b = box_length;
      endcase
      mul_p = 49'(mul_a) * 49'(mul_b);
   end

   always_comb begin
      for (int i = 0; i < 6; i++) nb[i] = lb_ff[i];
      for (int i = 0; i < 3; i++) begin
         e = 36'((acc_ff[i] + 51'd16384) >> 15);
         if (cur_ff.shape == csau_pkg::SHAPE_SPHERE) begin
            nb[i]     = csau_pkg::sat33(33'(c[i]) - 33'(sphere_radius));
            nb[i + 3] = csau_pkg::sat33(33'(c[i]) + 33'(sphere_radius));
         end else if (cur_ff.shape == csau_pkg::SHAPE_BOX) begin
            nb[i]     = csau_pkg::sat38(38'(c[i]) - 38'(e));
            nb[i + 3] = csau_pkg::sat38(38'(c[i]) + 38'(e));
         end
      end
   end

   always_comb begin
      st_in  = st_ff;
      k_in   = k_ff;
      col_in = col_ff;
      row_in = row_ff;
      case (st_ff)
         ST_IDLE: if (cmd_valid) st_in = (cmd_data.shape == csau_pkg::SHAPE_BOX)
                                          ? ST_QUAT : ST_DONE;
         ST_QUAT: begin
            st_in = ST_MAT;
         end
         ST_MAT: begin
            st_in  = ST_EXT;
            k_in   = '0;
            col_in = '0;
            row_in = '0;
         end
         ST_EXT: begin
            if (k_ff == 4'd8) begin
               st_in  = ST_DONE;
               k_in   = '0;
               col_in = '0;
               row_in = '0;
            end else begin
               k_in = k_ff + 1'b1;
               if (col_ff == 2'd2) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_DONE: if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         k_ff      <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         primed_ff <= 1'b0;
         ov_ff     <= 1'b0;
         for (int i = 0; i < 3; i++) lc_ff[i] <= '0;
         for (int i = 0; i < 6; i++) lb_ff[i] <= '0;
      end else begin
         st_ff  <= st_in;
         k_ff   <= k_in;
         col_ff <= col_in;
         row_ff <= row_in;
         if (st_ff == ST_DONE && out_free) begin
            ov_ff     <= 1'b1;
            primed_ff <= 1'b1;
            for (int i = 0; i < 3; i++) begin
               ob_ff[i]     <= (primed_ff && lb_ff[i] < nb[i]) ? lb_ff[i] : nb[i];
               ob_ff[i + 3] <= (primed_ff && lb_ff[i + 3] > nb[i + 3])
                               ? lb_ff[i + 3] : nb[i + 3];
               ob_ff[i + 6] <= primed_ff
                               ? csau_pkg::sat33(33'(c[i]) - 33'(lc_ff[i])) : '0;
               lc_ff[i]     <= c[i];
            end
            for (int i = 0; i < 6; i++) lb_ff[i] <= nb[i];
         end else if (!rsp_stall) begin
            ov_ff <= 1'b0;
         end
      end
      if (cmd_take) begin
         cur_ff <= cmd_data;
         for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
      end
      if (st_ff == ST_QUAT) begin
         for (int i = 0; i < 9; i++) pr_ff[i] <= 33'(prod[i]);
      end
      if (st_ff == ST_MAT) begin
         for (int i = 0; i < 9; i++)
            mag_ff[i] <= 18'(((m[i] < 0 ? -m[i] : m[i]) + 36'sd8192) >>> 14);
      end
      if (st_ff == ST_EXT) acc_ff[row_ff] <= acc_ff[row_ff] + 51'(mul_p);
   end

   assign rsp_valid      = ov_ff;
   assign rsp_swept_lo_x = ob_ff[0];
   assign rsp_swept_lo_y = ob_ff[1];
   assign rsp_swept_lo_z = ob_ff[2];
   assign rsp_swept_hi_x = ob_ff[3];
   assign rsp_swept_hi_y = ob_ff[4];
   assign rsp_swept_hi_z = ob_ff[5];
   assign rsp_move_dx    = ob_ff[6];
   assign rsp_move_dy    = ob_ff[7];
   assign rsp_move_dz    = ob_ff[8];

endmodule

// File: rtl/core/collider_swept_aabb_update_core.sv
// ---------------------------------------------------------------------------
// collider_swept_aabb_update_core
// swept bounding box of one collider from position and rotation per frame
// ---------------------------------------------------------------------------
//  channel  dir  handshake          contents
//  req_     in   valid / stall      position, quaternion
//  rsp_     out  valid / stall      swept box, center displacement
//  csr_     in   valid / ready      register index, write data
//
//  sphere or no shape: a transaction passes the idle and done states;
//  box: it passes in addition a product state, a matrix state and an
//  extent state in which the one shared multiplier does the nine
//  magnitude-by-extent products; one transaction is evaluated at a time
//  a two-entry command queue separates intake from evaluation
//  synchronous active-high reset clears control and configuration registers and previous box
//  a stalled result holds the output register and backs up the queue
module collider_swept_aabb_update_core #(
   parameter int unsigned QUEUE_DEPTH = csau_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic signed [15:0]  req_quat_w,
   input  logic signed [15:0]  req_quat_x,
   input  logic signed [15:0]  req_quat_y,
   input  logic signed [15:0]  req_quat_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_swept_lo_x,
   output logic signed [31:0]  rsp_swept_lo_y,
   output logic signed [31:0]  rsp_swept_lo_z,
   output logic signed [31:0]  rsp_swept_hi_x,
   output logic signed [31:0]  rsp_swept_hi_y,
   output logic signed [31:0]  rsp_swept_hi_z,
   output logic signed [31:0]  rsp_move_dx,
   output logic signed [31:0]  rsp_move_dy,
   output logic signed [31:0]  rsp_move_dz,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [31:0]         csr_index,
   input  logic [31:0]         csr_data
);

   logic [1:0]          shape_ff;
   logic signed [31:0]  offx_ff, offy_ff, offz_ff;
   logic [30:0]         bw_ff, bh_ff, bl_ff, rad_ff;
   logic                cmd_valid, cmd_take;
   csau_pkg::cmd_type   cmd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff <= csau_pkg::SHAPE_NONE;
         offx_ff  <= '0;
         offy_ff  <= '0;
         offz_ff  <= '0;
         bw_ff    <= '0;
         bh_ff    <= '0;
         bl_ff    <= '0;
         rad_ff   <= '0;
      end else if (csr_valid && csr_index[31:3] == '0) begin
         case (csr_index[2:0])
            csau_pkg::REG_SHAPE_KIND:    shape_ff <= csr_data[1:0];
            csau_pkg::REG_OFFSET_X:      offx_ff  <= csr_data;
            csau_pkg::REG_OFFSET_Y:      offy_ff  <= csr_data;
            csau_pkg::REG_OFFSET_Z:      offz_ff  <= csr_data;
            csau_pkg::REG_BOX_WIDTH:     bw_ff    <= csr_data[30:0];
            csau_pkg::REG_BOX_HEIGHT:    bh_ff    <= csr_data[30:0];
            csau_pkg::REG_BOX_LENGTH:    bl_ff    <= csr_data[30:0];
            csau_pkg::REG_SPHERE_RADIUS: rad_ff   <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   csau_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_stall,
      .req_pos_x, .req_pos_y, .req_pos_z,
      .req_quat_w, .req_quat_x, .req_quat_y, .req_quat_z,
      .shape_kind(shape_ff), .offset_x(offx_ff), .offset_y(offy_ff),
      .offset_z(offz_ff), .cmd_valid, .cmd_data, .cmd_take
   );

   csau_back u_back (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_take,
      .box_width(bw_ff), .box_height(bh_ff), .box_length(bl_ff),
      .sphere_radius(rad_ff), .rsp_valid, .rsp_stall,
      .rsp_swept_lo_x, .rsp_swept_lo_y, .rsp_swept_lo_z,
      .rsp_swept_hi_x, .rsp_swept_hi_y, .rsp_swept_hi_z,
      .rsp_move_dx, .rsp_move_dy, .rsp_move_dz
   );

endmodule
